>>> rtl/four_digit_seven_segment_driver_unit_macros.svh
// Assertion macros for the four-digit seven-segment driver.
// Included by the top level; no other dependencies.
`ifndef FOUR_DIGIT_SEVEN_SEGMENT_DRIVER_UNIT_MACROS_SVH
`define FOUR_DIGIT_SEVEN_SEGMENT_DRIVER_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is held.
`define FDSD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fdsd: implication check failed");

// Next-cycle implication, disabled while reset is held.
`define FDSD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fdsd: next-cycle check failed");

`endif

>>> rtl/fdsd_pkg.sv
// Shared types, constants and functions of the four-digit seven-segment driver.
// No dependencies; the other files of the block, but for the macro header, refer to it by scoped names.
package fdsd_pkg;

    localparam int NUMBER_WIDTH    = 16;
    localparam int VALUE_WIDTH     = 14;
    localparam int DIGIT_COUNT     = 4;
    localparam int DIGIT_IDX_WIDTH = 2;
    localparam int BCD_WIDTH       = 4;
    localparam int PAIR_WIDTH      = 7;
    localparam int SEG_WIDTH       = 8;
    localparam int CFG_INDEX_WIDTH = 2;
    localparam int CFG_DATA_WIDTH  = 1;
    localparam int QUEUE_DEPTH     = 2;

    localparam logic [NUMBER_WIDTH-1:0] CLAMP_MAX = 16'd9999;

    // n / 100 == (n * 5243) >> 19 for every n up to 9999.
    localparam int               DIV100_SHIFT = 19;
    localparam logic [12:0]      DIV100_MUL   = 13'd5243;
    // v / 10 == (v * 103) >> 10 for every v up to 99.
    localparam int               DIV10_SHIFT  = 10;
    localparam logic [6:0]       DIV10_MUL    = 7'd103;

    localparam logic [DIGIT_IDX_WIDTH-1:0] LAST_DIGIT  = 2'd3;
    localparam logic [DIGIT_COUNT-1:0]     ONES_ENABLE = 4'b1000;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_PIN_MODE     = 2'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_POLARITY     = 2'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MULTIPLEX_ON = 2'd2;

    typedef struct packed {
        logic pin_mode;
        logic polarity;
        logic multiplex_on;
    } disp_cfg_t;

    // bcd[0] is the ones digit, bcd[3] the thousands digit.
    typedef struct packed {
        logic [DIGIT_COUNT-1:0][BCD_WIDTH-1:0] bcd;
        logic                                  overflow;
    } digit_word_t;

    // Splits a value below 100 into {tens, ones}.
    function automatic logic [2*BCD_WIDTH-1:0] split_pair(input logic [PAIR_WIDTH-1:0] v);
        logic [2*PAIR_WIDTH-1:0] prod;
        logic [BCD_WIDTH-1:0]    tens;
        logic [PAIR_WIDTH-1:0]   ones;
        prod = (2*PAIR_WIDTH)'(v) * (2*PAIR_WIDTH)'(DIV10_MUL);
        tens = prod[DIV10_SHIFT +: BCD_WIDTH];
        ones = v - PAIR_WIDTH'(tens) * PAIR_WIDTH'(10);
        return {tens, ones[BCD_WIDTH-1:0]};
    endfunction

    function automatic logic [SEG_WIDTH-1:0] seg_pattern(input logic [BCD_WIDTH-1:0] digit,
                                                         input logic polarity);
        logic [SEG_WIDTH-1:0] pattern;
        case (digit)
            4'd0:    pattern = polarity ? 8'h3F : 8'hC0;
            4'd1:    pattern = polarity ? 8'h06 : 8'hF9;
            4'd2:    pattern = polarity ? 8'h5B : 8'hA4;
            4'd3:    pattern = polarity ? 8'h4F : 8'hB0;
            4'd4:    pattern = polarity ? 8'h66 : 8'h99;
            4'd5:    pattern = polarity ? 8'h6D : 8'h92;
            4'd6:    pattern = polarity ? 8'h7D : 8'h82;
            4'd7:    pattern = polarity ? 8'h07 : 8'hF8;
            4'd8:    pattern = polarity ? 8'h7F : 8'h80;
            4'd9:    pattern = polarity ? 8'h6F : 8'h90;
            default: pattern = '0;
        endcase
        return pattern;
    endfunction

    function automatic logic [SEG_WIDTH-1:0] encode_digit(input logic [BCD_WIDTH-1:0] digit,
                                                          input disp_cfg_t cfg);
        logic [SEG_WIDTH-1:0] code;
        if (cfg.pin_mode)
        begin
            code = seg_pattern(digit, cfg.polarity);
        end
        else
        begin
            code = {{(SEG_WIDTH-BCD_WIDTH){1'b0}}, digit};
        end
        return code;
    endfunction

endpackage

>>> rtl/fdsd_if.sv
// Handshake channels of the four-digit seven-segment driver: numbers in, digits out.
// Depends on fdsd_pkg for the field widths.
interface fdsd_in_if;
    logic                              valid;
    logic                              ready;
    logic [fdsd_pkg::NUMBER_WIDTH-1:0] number;

    modport source (output valid, output number, input ready);
    modport sink   (input valid, input number, output ready);
endinterface

interface fdsd_out_if;
    logic                             valid;
    logic                             ready;
    logic [fdsd_pkg::SEG_WIDTH-1:0]   segments;
    logic [fdsd_pkg::DIGIT_COUNT-1:0] digit_enable;
    logic                             overflow;
    logic                             last;

    modport source (output valid, output segments, output digit_enable, output overflow,
                    output last, input ready);
    modport sink   (input valid, input segments, input digit_enable, input overflow,
                    input last, output ready);
endinterface

>>> rtl/fdsd_front.sv
// Front end: accepts numbers, clamps them and splits them into four BCD digits.
// Depends on fdsd_pkg and fdsd_in_if.
module fdsd_front (
    input  logic                  clk,
    input  logic                  rst_n,
    fdsd_in_if.sink               num_ch,
    output fdsd_pkg::digit_word_t word,
    output logic                  word_valid,
    input  logic                  word_ready
);

    localparam int ProdWidth = fdsd_pkg::VALUE_WIDTH + 13;

    logic                                 a_valid_reg;
    logic [fdsd_pkg::VALUE_WIDTH-1:0]     a_value_reg;
    logic                                 a_ovf_reg;
    logic                                 b_valid_reg;
    logic [fdsd_pkg::PAIR_WIDTH-1:0]      b_high_reg;
    logic [fdsd_pkg::PAIR_WIDTH-1:0]      b_low_reg;
    logic                                 b_ovf_reg;

    logic                                 advance_a;
    logic                                 advance_b;
    logic                                 clamp;
    logic [fdsd_pkg::VALUE_WIDTH-1:0]     clamped;
    logic [ProdWidth-1:0]                 prod;
    logic [fdsd_pkg::PAIR_WIDTH-1:0]      quot;
    logic [fdsd_pkg::VALUE_WIDTH-1:0]     rem;
    logic [2*fdsd_pkg::BCD_WIDTH-1:0]     high_pair;
    logic [2*fdsd_pkg::BCD_WIDTH-1:0]     low_pair;

    // Each stage moves on when the one after it is empty or moving on too.
    assign advance_b    = !b_valid_reg || word_ready;
    assign advance_a    = !a_valid_reg || advance_b;
    assign num_ch.ready = advance_a;

    assign clamp   = num_ch.number > fdsd_pkg::CLAMP_MAX;
    assign clamped = clamp ? fdsd_pkg::CLAMP_MAX[fdsd_pkg::VALUE_WIDTH-1:0]
                           : num_ch.number[fdsd_pkg::VALUE_WIDTH-1:0];

    assign prod = ProdWidth'(a_value_reg) * ProdWidth'(fdsd_pkg::DIV100_MUL);
    assign quot = prod[fdsd_pkg::DIV100_SHIFT +: fdsd_pkg::PAIR_WIDTH];
    assign rem  = a_value_reg - fdsd_pkg::VALUE_WIDTH'(quot) * fdsd_pkg::VALUE_WIDTH'(100);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance_a)
            begin
                a_valid_reg <= num_ch.valid;
            end
            if (advance_b)
            begin
                b_valid_reg <= a_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance_a && num_ch.valid)
        begin
            a_value_reg <= clamped;
            a_ovf_reg   <= clamp;
        end
        if (advance_b && a_valid_reg)
        begin
            b_high_reg <= quot;
            b_low_reg  <= rem[fdsd_pkg::PAIR_WIDTH-1:0];
            b_ovf_reg  <= a_ovf_reg;
        end
    end

    assign high_pair = fdsd_pkg::split_pair(b_high_reg);
    assign low_pair  = fdsd_pkg::split_pair(b_low_reg);

    assign word.bcd[3]   = high_pair[2*fdsd_pkg::BCD_WIDTH-1:fdsd_pkg::BCD_WIDTH];
    assign word.bcd[2]   = high_pair[fdsd_pkg::BCD_WIDTH-1:0];
    assign word.bcd[1]   = low_pair[2*fdsd_pkg::BCD_WIDTH-1:fdsd_pkg::BCD_WIDTH];
    assign word.bcd[0]   = low_pair[fdsd_pkg::BCD_WIDTH-1:0];
    assign word.overflow = b_ovf_reg;
    assign word_valid    = b_valid_reg;

endmodule

>>> rtl/fdsd_queue.sv
// Short first-in first-out queue of split numbers between front and back end.
// Depends on fdsd_pkg for the word type.
module fdsd_queue #(
    parameter int DEPTH = fdsd_pkg::QUEUE_DEPTH
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fdsd_pkg::digit_word_t push_word,
    input  logic                  push_valid,
    output logic                  push_ready,
    output fdsd_pkg::digit_word_t pop_word,
    output logic                  pop_valid,
    input  logic                  pop_ready
);

    localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CountWidth = $clog2(DEPTH + 1);

    fdsd_pkg::digit_word_t  entries_reg [DEPTH];
    logic [PtrWidth-1:0]    wr_ptr_reg;
    logic [PtrWidth-1:0]    rd_ptr_reg;
    logic [CountWidth-1:0]  count_reg;
    logic [CountWidth-1:0]  count_next;
    logic                   do_push;
    logic                   do_pop;

    assign push_ready = count_reg != CountWidth'(DEPTH);
    assign pop_valid  = count_reg != '0;
    assign pop_word   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CountWidth'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CountWidth'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0
                                                                   : wr_ptr_reg + PtrWidth'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PtrWidth'(DEPTH - 1)) ? '0
                                                                   : rd_ptr_reg + PtrWidth'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_word;
        end
    end

endmodule

>>> rtl/fdsd_back.sv
// Back end: walks the digits of the queued word and drives the registered output word.
// Depends on fdsd_pkg and fdsd_out_if.
module fdsd_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  fdsd_pkg::disp_cfg_t   cfg,
    input  fdsd_pkg::digit_word_t word,
    input  logic                  word_valid,
    output logic                  word_ready,
    fdsd_out_if.source            seg_ch
);

    logic [fdsd_pkg::DIGIT_IDX_WIDTH-1:0] digit_idx_reg;
    logic                                 out_valid_reg;
    logic [fdsd_pkg::SEG_WIDTH-1:0]       segments_reg;
    logic [fdsd_pkg::DIGIT_COUNT-1:0]     digit_enable_reg;
    logic                                 overflow_reg;
    logic                                 last_reg;

    logic                                 is_last;
    logic                                 emit;

    assign is_last    = !cfg.multiplex_on || (digit_idx_reg == fdsd_pkg::LAST_DIGIT);
    // A new digit goes out whenever the output register is empty or being emptied.
    assign emit       = word_valid && (!out_valid_reg || seg_ch.ready);
    assign word_ready = emit && is_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            digit_idx_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (emit)
            begin
                out_valid_reg <= 1'b1;
                digit_idx_reg <= is_last ? '0
                                         : digit_idx_reg + fdsd_pkg::DIGIT_IDX_WIDTH'(1);
            end
            else if (seg_ch.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            segments_reg     <= fdsd_pkg::encode_digit(word.bcd[digit_idx_reg], cfg);
            digit_enable_reg <= fdsd_pkg::ONES_ENABLE >> digit_idx_reg;
            overflow_reg     <= word.overflow;
            last_reg         <= is_last;
        end
    end

    assign seg_ch.valid        = out_valid_reg;
    assign seg_ch.segments     = segments_reg;
    assign seg_ch.digit_enable = digit_enable_reg;
    assign seg_ch.overflow     = overflow_reg;
    assign seg_ch.last         = last_reg;

endmodule

>>> rtl/four_digit_seven_segment_driver_unit.sv
// Top level of the four-digit seven-segment driver: configuration registers,
// front end, word queue and back end. Depends on fdsd_pkg, fdsd_if and the macro header.
//
// Usage:
//   num_ch takes one 16-bit number per word; values above 9999 show as 9999 with
//   overflow set on every digit of that number.
//   seg_ch gives one word per displayed digit, ones first through thousands, with a
//   one-hot digit_enable (bit 3 = ones) and last on the final digit. With
//   multiplex_on cleared only the ones digit is sent, with last set.
//   A number passes the two front-end stages and the queue before its first digit
//   is registered at the output. The back end sends one digit per cycle while the
//   receiver is ready; that output loop sets the sustained rate.
//   The front end splits in a two-stage pipeline and keeps accepting numbers until
//   the queue between the two halves and its own stages are full.
//   A stalled receiver holds the output word steady; the back end waits, the queue
//   and then the front-end stages fill, and num_ch.ready drops.
//   Configuration is written through cfg_we, cfg_index and cfg_data while the block
//   is idle; writes to an index past the last register are ignored.
//   Reset empties every stage and restores pin_mode = 1, polarity = 0,
//   multiplex_on = 1.
`include "four_digit_seven_segment_driver_unit_macros.svh"

module four_digit_seven_segment_driver_unit #(
    parameter int QUEUE_DEPTH = fdsd_pkg::QUEUE_DEPTH
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [fdsd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [fdsd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data,
    fdsd_in_if.sink                              num_ch,
    fdsd_out_if.source                           seg_ch
);

    logic                  pin_mode_reg;
    logic                  polarity_reg;
    logic                  multiplex_on_reg;
    fdsd_pkg::disp_cfg_t   cfg;

    fdsd_pkg::digit_word_t front_word;
    logic                  front_valid;
    logic                  front_ready;
    fdsd_pkg::digit_word_t back_word;
    logic                  back_valid;
    logic                  back_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pin_mode_reg     <= 1'b1;
            polarity_reg     <= 1'b0;
            multiplex_on_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                fdsd_pkg::CFG_PIN_MODE:     pin_mode_reg     <= cfg_data[0];
                fdsd_pkg::CFG_POLARITY:     polarity_reg     <= cfg_data[0];
                fdsd_pkg::CFG_MULTIPLEX_ON: multiplex_on_reg <= cfg_data[0];
                default:                    ;
            endcase
        end
    end

    assign cfg.pin_mode     = pin_mode_reg;
    assign cfg.polarity     = polarity_reg;
    assign cfg.multiplex_on = multiplex_on_reg;

    fdsd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .num_ch     (num_ch),
        .word       (front_word),
        .word_valid (front_valid),
        .word_ready (front_ready)
    );

    fdsd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_word  (front_word),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .pop_word   (back_word),
        .pop_valid  (back_valid),
        .pop_ready  (back_ready)
    );

    fdsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .word       (back_word),
        .word_valid (back_valid),
        .word_ready (back_ready),
        .seg_ch     (seg_ch)
    );

    // Exactly one display is selected on every output word.
    `FDSD_ASSERT_IMP(a_enable_onehot, clk, rst_n, seg_ch.valid, $onehot(seg_ch.digit_enable))

    // Without multiplexing each number is a single ones-digit word.
    `FDSD_ASSERT_IMP(a_single_digit, clk, rst_n, seg_ch.valid && !multiplex_on_reg, seg_ch.last && (seg_ch.digit_enable == fdsd_pkg::ONES_ENABLE))

    // With multiplexing the thousands digit, and only it, closes a number.
    `FDSD_ASSERT_IMP(a_last_thousands, clk, rst_n, seg_ch.valid && multiplex_on_reg, seg_ch.last == seg_ch.digit_enable[0])

    // Digits of one number follow without a gap, moving one display up each time.
    `FDSD_ASSERT_NEXT(a_digit_burst, clk, rst_n, seg_ch.valid && seg_ch.ready && !seg_ch.last, seg_ch.valid && (seg_ch.digit_enable == ($past(seg_ch.digit_enable) >> 1)))

endmodule

>>> verif/four_digit_seven_segment_driver_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench for four_digit_seven_segment_driver_unit: drives numbers,
// predicts the digit words per display setting and checks them in order.
// Depends on fdsd_pkg, fdsd_if and the block's top level.
module four_digit_seven_segment_driver_unit_tb;

    localparam int STALL_LIMIT   = 3000;
    localparam int SETTLE_CYCLES = 8;
    localparam int LONG_HOLD     = 120;
    localparam int PHASE_COUNT   = 8;
    localparam int PHASE_ITEMS   = 54;
    localparam int CLAMP_VALUE   = 9999;

    // Index past the last register; writes there must change nothing.
    localparam logic [fdsd_pkg::CFG_INDEX_WIDTH-1:0] CFG_UNUSED = 2'd3;

    localparam fdsd_pkg::disp_cfg_t RESET_CFG = 3'b101;

    typedef struct packed {
        logic [7:0] segments;
        logic [3:0] digit_enable;
        logic       overflow;
        logic       last;
    } digit_word_t;

    typedef struct {
        fdsd_pkg::disp_cfg_t cfg;
        logic [15:0]         number;
        bit                  typed;
        logic [7:0]          seg;
        logic                ovf;
    } directed_row_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [fdsd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index;
    logic [fdsd_pkg::CFG_DATA_WIDTH-1:0]  cfg_data;

    fdsd_in_if  num_ch ();
    fdsd_out_if seg_ch ();

    four_digit_seven_segment_driver_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .num_ch    (num_ch),
        .seg_ch    (seg_ch)
    );

    always #5 clk = ~clk;

    logic [7:0] anode_seg [10] = '{8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99,
                                   8'h92, 8'h82, 8'hF8, 8'h80, 8'h90};
    logic [7:0] cathode_seg [10] = '{8'h3F, 8'h06, 8'h5B, 8'h4F, 8'h66,
                                     8'h6D, 8'h7D, 8'h07, 8'h7F, 8'h6F};

    // The ones-digit word is typed in where it is obvious; the rest comes from the predictor.
    directed_row_t directed_rows [23] = '{
        '{3'b101, 16'd0,     1'b1, 8'hC0, 1'b0},
        '{3'b101, 16'd9999,  1'b1, 8'h90, 1'b0},
        '{3'b101, 16'd10000, 1'b1, 8'h90, 1'b1},
        '{3'b101, 16'd65535, 1'b1, 8'h90, 1'b1},
        '{3'b101, 16'd1234,  1'b0, 8'h00, 1'b0},
        '{3'b101, 16'd5678,  1'b0, 8'h00, 1'b0},
        '{3'b101, 16'd9000,  1'b0, 8'h00, 1'b0},
        '{3'b101, 16'd9998,  1'b1, 8'h80, 1'b0},
        '{3'b111, 16'd0,     1'b1, 8'h3F, 1'b0},
        '{3'b111, 16'd7,     1'b1, 8'h07, 1'b0},
        '{3'b111, 16'd12345, 1'b1, 8'h6F, 1'b1},
        '{3'b111, 16'd2468,  1'b0, 8'h00, 1'b0},
        '{3'b001, 16'd4321,  1'b1, 8'h01, 1'b0},
        '{3'b001, 16'd65535, 1'b1, 8'h09, 1'b1},
        '{3'b001, 16'd0,     1'b1, 8'h00, 1'b0},
        '{3'b011, 16'd5555,  1'b1, 8'h05, 1'b0},
        '{3'b100, 16'd6,     1'b1, 8'h82, 1'b0},
        '{3'b100, 16'd40000, 1'b1, 8'h90, 1'b1},
        '{3'b100, 16'd13,    1'b0, 8'h00, 1'b0},
        '{3'b110, 16'd3,     1'b1, 8'h4F, 1'b0},
        '{3'b000, 16'd9999,  1'b1, 8'h09, 1'b0},
        '{3'b000, 16'd32768, 1'b1, 8'h09, 1'b1},
        '{3'b000, 16'h5A5A,  1'b0, 8'h00, 1'b0}
    };

    fdsd_pkg::disp_cfg_t display_cfg = RESET_CFG;
    digit_word_t         digits_due [$];
    digit_word_t         due_word;
    int                  mismatches  = 0;
    int                  idle_cycles = 0;
    bit                  tx_idle_on  = 1'b1;
    bit                  rx_idle_on  = 1'b1;
    bit                  hold_req    = 1'b0;

    // Appends the digit words that one accepted number should produce.
    function automatic void predict_digits(input logic [15:0] number);
        int unsigned value;
        int unsigned scale;
        logic        ovf;
        int          count;
        logic [3:0]  dig;
        digit_word_t w;
        value = number;
        ovf   = 1'b0;
        if (value > CLAMP_VALUE)
        begin
            value = CLAMP_VALUE;
            ovf   = 1'b1;
        end
        count = display_cfg.multiplex_on ? 4 : 1;
        scale = 1;
        for (int k = 0; k < count; k++)
        begin
            dig = 4'((value / scale) % 10);
            if (!display_cfg.pin_mode)
                w.segments = {4'h0, dig};
            else if (display_cfg.polarity)
                w.segments = cathode_seg[dig];
            else
                w.segments = anode_seg[dig];
            w.digit_enable = 4'b1000 >> k;
            w.overflow     = ovf;
            w.last         = (k == count - 1);
            digits_due.push_back(w);
            scale = scale * 10;
        end
    endfunction

    function automatic logic [15:0] pick_number();
        int sel;
        sel = $urandom_range(0, 9);
        if (sel <= 4)
            return 16'($urandom_range(0, CLAMP_VALUE));
        else if (sel == 5)
            return 16'($urandom_range(CLAMP_VALUE - 9, CLAMP_VALUE + 11));
        else if (sel == 6)
            return 16'($urandom_range(CLAMP_VALUE + 1, 65535));
        else if (sel <= 8)
            return 16'($urandom);
        case ($urandom_range(0, 3))
            0:       return 16'd0;
            1:       return 16'd9999;
            2:       return 16'd10000;
            default: return 16'hFFFF;
        endcase
    endfunction

    // Offers one number and waits until the block takes it; valid stays high afterward.
    task automatic send_number(input logic [15:0] n, input bit typed,
                               input logic [7:0] t_seg, input logic t_ovf);
        int first;
        @(negedge clk);
        num_ch.valid  = 1'b1;
        num_ch.number = n;
        @(posedge clk);
        while (!num_ch.ready)
            @(posedge clk);
        first = digits_due.size();
        predict_digits(n);
        if (typed)
        begin
            digits_due[first].segments = t_seg;
            digits_due[first].overflow = t_ovf;
        end
    endtask

    task automatic idle_sender(input int cycles);
        @(negedge clk);
        num_ch.valid = 1'b0;
        repeat (cycles - 1)
            @(negedge clk);
    endtask

    task automatic wait_drained();
        @(negedge clk);
        num_ch.valid = 1'b0;
        while (digits_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    task automatic apply_cfg(input fdsd_pkg::disp_cfg_t c);
        wait_drained();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = fdsd_pkg::CFG_PIN_MODE;
        cfg_data  = c.pin_mode;
        @(negedge clk);
        cfg_index = fdsd_pkg::CFG_POLARITY;
        cfg_data  = c.polarity;
        @(negedge clk);
        cfg_index = fdsd_pkg::CFG_MULTIPLEX_ON;
        cfg_data  = c.multiplex_on;
        @(negedge clk);
        cfg_index = CFG_UNUSED;
        cfg_data  = 1'($urandom_range(0, 1));
        @(negedge clk);
        cfg_we = 1'b0;
        display_cfg = c;
    endtask

    // Receiver: random stall bursts, plus one long hold-off on request.
    initial
    begin
        seg_ch.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req     = 1'b0;
                seg_ch.ready = 1'b0;
                repeat (LONG_HOLD - 1)
                    @(negedge clk);
            end
            else if (rx_idle_on && $urandom_range(0, 7) == 0)
            begin
                seg_ch.ready = 1'b0;
                repeat ($urandom_range(1, 17) - 1)
                    @(negedge clk);
            end
            else
            begin
                seg_ch.ready = 1'b1;
            end
        end
    end

    // Each digit word taken from the block is checked against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && seg_ch.valid && seg_ch.ready)
        begin
            if (digits_due.size() == 0)
            begin
                $error("unexpected digit word: segments %0h, digit_enable %0h",
                       seg_ch.segments, seg_ch.digit_enable);
                mismatches++;
            end
            else
            begin
                due_word = digits_due.pop_front();
                if (seg_ch.segments !== due_word.segments)
                begin
                    $error("segments: expected %0h, got %0h",
                           due_word.segments, seg_ch.segments);
                    mismatches++;
                end
                if (seg_ch.digit_enable !== due_word.digit_enable)
                begin
                    $error("digit_enable: expected %0h, got %0h",
                           due_word.digit_enable, seg_ch.digit_enable);
                    mismatches++;
                end
                if (seg_ch.overflow !== due_word.overflow)
                begin
                    $error("overflow: expected %0b, got %0b",
                           due_word.overflow, seg_ch.overflow);
                    mismatches++;
                end
                if (seg_ch.last !== due_word.last)
                begin
                    $error("last: expected %0b, got %0b", due_word.last, seg_ch.last);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a word.
    always @(posedge clk)
    begin
        if (!rst_n || (num_ch.valid && num_ch.ready) || (seg_ch.valid && seg_ch.ready))
        begin
            idle_cycles <= 0;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    initial
    begin
        fdsd_pkg::disp_cfg_t phase_cfg;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        num_ch.valid  = 1'b0;
        num_ch.number = '0;
        repeat (6)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed rows start in the reset setting, so the reset values are checked too.
        for (int i = 0; i < $size(directed_rows); i++)
        begin
            if (directed_rows[i].cfg != display_cfg)
                apply_cfg(directed_rows[i].cfg);
            send_number(directed_rows[i].number, directed_rows[i].typed,
                        directed_rows[i].seg, directed_rows[i].ovf);
        end

        for (int p = 0; p < PHASE_COUNT; p++)
        begin
            if (p == 0)
                phase_cfg = 3'b000;
            else if (p == 1)
                phase_cfg = 3'b111;
            else
                phase_cfg = 3'($urandom_range(0, 7));
            apply_cfg(phase_cfg);
            if (p == PHASE_COUNT - 1)
            begin
                tx_idle_on = 1'b0;
                rx_idle_on = 1'b0;
            end
            for (int i = 0; i < PHASE_ITEMS; i++)
            begin
                if (p == 2 && i == 10)
                    hold_req = 1'b1;
                if (p == 4 && i == 20)
                    wait_drained();
                if (tx_idle_on && $urandom_range(0, 5) == 0)
                    idle_sender($urandom_range(1, 17));
                send_number(pick_number(), 1'b0, 8'h00, 1'b0);
            end
        end

        wait_drained();
        repeat (SETTLE_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
